FILE: sv/wpd_pkg.sv
// Shared types and constants for the WAVE PCM parser and downmixer.
package wpd_pkg;

  localparam int unsigned DivW = 34;
  localparam int unsigned DsrW = 16;
  localparam int unsigned CntW = $clog2(DivW);

  localparam logic [31:0] FileLenRst = 32'd67108864;
  localparam logic [31:0] TagRiff    = 32'h46464952;
  localparam logic [31:0] TagWave    = 32'h45564157;
  localparam logic [31:0] TagFmt     = 32'h20746D66;
  localparam logic [31:0] TagData    = 32'h61746164;

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindInfo   = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  localparam logic ErrFormat = 1'b0;
  localparam logic ErrEmpty  = 1'b1;

  typedef enum logic [2:0] {
    PhHead,
    PhHdr,
    PhSkip,
    PhFmt,
    PhData,
    PhDone
  } phase_e;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlFrames,
    CtlMono
  } ctl_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/wpd_if.sv
// Handshake channel interfaces for byte input, results and configuration.
interface wpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface wpd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [31:0]        sample_rate;
  logic [31:0]        frame_count;
  logic               error_code;
  logic               is_last;
  modport source (output valid, output kind, output sample, output sample_rate,
                  output frame_count, output error_code, output is_last, input ready);
  modport sink (input valid, input kind, input sample, input sample_rate,
                input frame_count, input error_code, input is_last, output ready);
endinterface

interface wpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] file_length;
  modport source (output valid, output file_length, input ready);
  modport sink (input valid, input file_length, output ready);
endinterface

FILE: sv/wav_pcm_parse_downmix_core.sv
// RIFF/WAVE PCM parser with mono downmix: top level with byte sequencer.
// A byte is normally taken without a divide. The byte that ends the data chunk header and the
// byte that completes a frame start the shared 34-step serial divider; that byte goes through
// accept, 34 divide steps and result, during which the input is not ready.
// Result beats leave through an output register; a new byte is taken while the last result
// is being consumed. Writes to file_length do not restart parsing.
module wav_pcm_parse_downmix_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  wpd_in_if.sink    in_i,
  wpd_out_if.source out_o,
  wpd_cfg_if.sink   cfg_i
);
  import wpd_pkg::*;

  phase_e             phase_q, phase_d;
  ctl_e               ctl_q, ctl_d;
  logic [31:0]        fl_q, fl_d;
  logic [31:0]        pos_q, pos_d;
  logic [31:0]        tag_q, tag_d;
  logic [31:0]        len_q, len_d;
  logic [31:0]        skip_q, skip_d;
  logic [63:0]        fmt_q, fmt_d;
  logic [31:0]        frames_q, frames_d;
  logic signed [33:0] sum_q, sum_d;
  logic [15:0]        chidx_q, chidx_d;
  logic [7:0]         low_q, low_d;
  logic [3:0]         fidx_q, fidx_d;
  logic [15:0]        bits_q, bits_d;
  logic               want_q, want_d;
  logic               neg_q, neg_d;

  logic               ov_q, ov_d;
  logic [1:0]         okind_q, okind_d;
  logic [15:0]        osmp_q, osmp_d;
  logic [31:0]        orate_q, orate_d;
  logic [31:0]        ofrm_q, ofrm_d;
  logic               oerr_q, oerr_d;
  logic               olast_q, olast_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        accept;
  logic        produce;
  logic        do_skip;
  logic [32:0] skip_v;
  logic [32:0] next_v;
  logic [34:0] end_v;
  logic [2:0]  k3;
  logic [3:0]  k4;
  logic [15:0] ch;
  logic signed [16:0] v;
  logic [33:0] q_s;
  logic [31:0] frm_v;

  wpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready  = (ctl_q == CtlIdle) && (!ov_q || out_o.ready);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    phase_d  = phase_q;
    ctl_d    = ctl_q;
    fl_d     = fl_q;
    pos_d    = pos_q;
    tag_d    = tag_q;
    len_d    = len_q;
    skip_d   = skip_q;
    fmt_d    = fmt_q;
    frames_d = frames_q;
    sum_d    = sum_q;
    chidx_d  = chidx_q;
    low_d    = low_q;
    fidx_d   = fidx_q;
    bits_d   = bits_q;
    want_d   = want_q;
    neg_d    = neg_q;
    produce  = 1'b0;
    okind_d  = okind_q;
    osmp_d   = osmp_q;
    orate_d  = orate_q;
    ofrm_d   = ofrm_q;
    oerr_d   = oerr_q;
    olast_d  = olast_q;
    div_req  = '0;
    do_skip  = 1'b0;
    skip_v   = '0;
    next_v   = '0;
    end_v    = '0;
    k3       = '0;
    k4       = '0;
    ch       = fmt_q[31:16];
    v        = '0;
    q_s      = '0;
    frm_v    = '0;

    if (cfg_i.valid) begin
      fl_d = cfg_i.file_length;
    end

    if (accept) begin
      if (in_i.first_byte) begin
        phase_d  = PhHead;
        pos_d    = '0;
        tag_d    = '0;
        len_d    = '0;
        skip_d   = '0;
        fmt_d    = '0;
        frames_d = '0;
        sum_d    = '0;
        chidx_d  = '0;
        low_d    = '0;
        fidx_d   = '0;
        bits_d   = '0;
        want_d   = 1'b0;
      end
      ch     = fmt_d[31:16];
      next_v = {1'b0, pos_d} + 33'd1;
      if (phase_d != PhDone) begin
        pos_d = next_v[31:0];
      end
      okind_d = KindError;
      osmp_d  = '0;
      orate_d = '0;
      ofrm_d  = '0;
      oerr_d  = ErrFormat;
      olast_d = 1'b1;
      case (phase_d)
        PhHead: begin
          tag_d = tag_d | ({24'b0, in_i.data_byte} << {2'(next_v[1:0] - 2'd1), 3'b000});
          if (in_i.first_byte && fl_q < 32'd12) begin
            produce = 1'b1;
          end else if (!in_i.first_byte && pos_q == '0 && fl_q < 32'd12) begin
            produce = 1'b1;
          end else begin
            if (pos_d == 32'd4) begin
              if (tag_d != TagRiff) produce = 1'b1;
              tag_d = '0;
            end else if (pos_d == 32'd8) begin
              tag_d = '0;
            end else if (pos_d == 32'd12) begin
              if (tag_d != TagWave) begin
                produce = 1'b1;
              end else begin
                want_d  = 1'b0;
                do_skip = 1'b1;
                skip_v  = '0;
              end
            end
          end
        end
        PhHdr: begin
          k3     = fidx_d[2:0];
          fidx_d = {1'b0, k3} + 4'd1;
          if (!k3[2]) begin
            tag_d = tag_d | ({24'b0, in_i.data_byte} << {k3[1:0], 3'b000});
          end else begin
            len_d = len_d | ({24'b0, in_i.data_byte} << {k3[1:0], 3'b000});
          end
          if (k3 == 3'd7) begin
            if (!want_d && tag_d == TagFmt) begin
              if (len_d < 32'd16 || ({2'b0, next_v} + 35'd16) > {3'b0, fl_q}) begin
                produce = 1'b1;
              end else begin
                phase_d = PhFmt;
                fidx_d  = '0;
                fmt_d   = '0;
                bits_d  = '0;
              end
            end else if (want_d && tag_d == TagData) begin
              if (({2'b0, next_v} + {3'b0, len_d}) > {3'b0, fl_q} || ch == '0) begin
                produce = 1'b1;
              end else begin
                ctl_d            = CtlFrames;
                div_req.start    = 1'b1;
                div_req.dividend = {2'b0, len_d};
                div_req.divisor  = ch;
              end
            end else begin
              do_skip = 1'b1;
              skip_v  = {1'b0, len_d} + {32'b0, len_d[0]};
            end
          end
        end
        PhSkip: begin
          if (skip_d != '0) skip_d = skip_d - 32'd1;
          if (skip_d == '0) begin
            phase_d = PhHdr;
            fidx_d  = '0;
            tag_d   = '0;
            len_d   = '0;
          end
        end
        PhFmt: begin
          k4     = fidx_d;
          fidx_d = k4 + 4'd1;
          if (!k4[3]) begin
            fmt_d = fmt_d | ({56'b0, in_i.data_byte} << {k4[2:0], 3'b000});
          end else if (k4 == 4'd14) begin
            bits_d = {8'b0, in_i.data_byte};
          end else if (k4 == 4'd15) begin
            bits_d = bits_d | {in_i.data_byte, 8'b0};
          end
          if (k4 == 4'd15) begin
            if (fmt_d[15:0] != 16'd1 || fmt_d[31:16] == '0 ||
                (bits_d != 16'd8 && bits_d != 16'd16)) begin
              produce = 1'b1;
            end else begin
              want_d  = 1'b1;
              do_skip = 1'b1;
              skip_v  = {1'b0, len_d} - 33'd16 + {32'b0, len_d[0]};
            end
          end
        end
        PhData: begin
          if (bits_d == 16'd16) begin
            if (fidx_d == '0) begin
              low_d  = in_i.data_byte;
              fidx_d = 4'd1;
            end else begin
              fidx_d = '0;
              v      = {in_i.data_byte[7], in_i.data_byte, low_d};
            end
          end else begin
            v = $signed({9'b0, in_i.data_byte}) - 17'sd128;
          end
          if (bits_d != 16'd16 || fidx_q != '0) begin
            sum_d   = sum_d + {{17{v[16]}}, v};
            chidx_d = chidx_d + 16'd1;
            if (chidx_d >= ch && ch != '0) begin
              ctl_d            = CtlMono;
              neg_d            = sum_d[33];
              div_req.start    = 1'b1;
              div_req.dividend = sum_d[33] ? 34'(-sum_d) : sum_d;
              div_req.divisor  = ch;
              sum_d            = '0;
              chidx_d          = '0;
            end
          end
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
      if (do_skip) begin
        end_v = {2'b0, next_v} + {2'b0, skip_v} + 35'd8;
        if (end_v > {3'b0, fl_q}) begin
          produce = 1'b1;
        end else if (skip_v == '0) begin
          phase_d = PhHdr;
          fidx_d  = '0;
          tag_d   = '0;
          len_d   = '0;
        end else begin
          phase_d = PhSkip;
          skip_d  = skip_v[31:0];
        end
      end
      if (produce) begin
        phase_d = PhDone;
      end
    end else if (div_rsp.done) begin
      ctl_d   = CtlIdle;
      produce = 1'b1;
      osmp_d  = '0;
      orate_d = '0;
      ofrm_d  = '0;
      oerr_d  = ErrFormat;
      olast_d = 1'b0;
      if (ctl_q == CtlFrames) begin
        frm_v = (bits_q == 16'd16) ? {1'b0, div_rsp.quotient[31:1]} : div_rsp.quotient[31:0];
        if (frm_v == '0) begin
          okind_d = KindError;
          oerr_d  = ErrEmpty;
          olast_d = 1'b1;
          phase_d = PhDone;
        end else begin
          okind_d  = KindInfo;
          orate_d  = fmt_q[63:32];
          ofrm_d   = frm_v;
          phase_d  = PhData;
          frames_d = frm_v;
          sum_d    = '0;
          chidx_d  = '0;
          fidx_d   = '0;
        end
      end else begin
        q_s = neg_q ? (-div_rsp.quotient) : div_rsp.quotient;
        if (bits_q != 16'd16) q_s = q_s << 8;
        okind_d = KindSample;
        osmp_d  = q_s[15:0];
        if (frames_d != '0) frames_d = frames_d - 32'd1;
        if (frames_d == '0) begin
          olast_d = 1'b1;
          phase_d = PhDone;
        end
      end
    end
  end

  assign ov_d = (ov_q && !out_o.ready) || produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHead;
      ctl_q    <= CtlIdle;
      fl_q     <= FileLenRst;
      pos_q    <= '0;
      tag_q    <= '0;
      len_q    <= '0;
      skip_q   <= '0;
      fmt_q    <= '0;
      frames_q <= '0;
      sum_q    <= '0;
      chidx_q  <= '0;
      low_q    <= '0;
      fidx_q   <= '0;
      bits_q   <= '0;
      want_q   <= 1'b0;
      neg_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ctl_q    <= ctl_d;
      fl_q     <= fl_d;
      pos_q    <= pos_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      skip_q   <= skip_d;
      fmt_q    <= fmt_d;
      frames_q <= frames_d;
      sum_q    <= sum_d;
      chidx_q  <= chidx_d;
      low_q    <= low_d;
      fidx_q   <= fidx_d;
      bits_q   <= bits_d;
      want_q   <= want_d;
      neg_q    <= neg_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    osmp_q  <= osmp_d;
    orate_q <= orate_d;
    ofrm_q  <= ofrm_d;
    oerr_q  <= oerr_d;
    olast_q <= olast_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.kind        = okind_q;
  assign out_o.sample      = osmp_q;
  assign out_o.sample_rate = orate_q;
  assign out_o.frame_count = ofrm_q;
  assign out_o.error_code  = oerr_q;
  assign out_o.is_last     = olast_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q != CtlIdle |-> !in_i.ready) else $error("byte taken during divide");
  a_div_matches_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> ctl_q != CtlIdle) else $error("divider runs with idle sequencer");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce && olast_d |=> phase_q == PhDone) else $error("last beat without stop");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |-> !ov_q || out_o.ready) else $error("result overwrites pending beat");
endmodule

FILE: sv/wpd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module wpd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpd_pkg::div_req_t req_i,
  output wpd_pkg::div_rsp_t rsp_o
);
  import wpd_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DsrW:0]   rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [DsrW:0]   rem_sh;
  logic            qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q[DsrW-1:0], quo_q[DivW-1]};
    qbit   = (rem_sh >= {1'b0, dsr_q});
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = qbit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_d = {quo_q[DivW-2:0], qbit};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !done_q) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a run");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= CntW'(DivW - 1)) else $error("divider count overrun");
endmodule

FILE: sim/wpd_tb_if.sv
`timescale 1ns / 100ps
// Result beat record type shared by the bench.
package wpd_tb_pkg;
  import wpd_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [31:0]        sample_rate;
    logic [31:0]        frame_count;
    logic               error_code;
    logic               is_last;
  } wav_result_t;
endpackage

FILE: sim/tb_wav_pcm_parse_downmix_core.sv
`timescale 1ns / 100ps
// Regression bench: feeds WAVE byte streams and checks results against a predictor.
module tb_wav_pcm_parse_downmix_core;
  import wpd_pkg::*;
  import wpd_tb_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  logic clk_i;
  logic rst_ni;

  wpd_in_if  in_ch ();
  wpd_out_if out_ch ();
  wpd_cfg_if cfg_ch ();

  wav_pcm_parse_downmix_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // predictor state
  logic [31:0] m_file_len;
  phase_e      m_phase;
  logic [31:0] m_pos;
  logic [31:0] m_tag;
  logic [31:0] m_clen;
  logic [31:0] m_skip;
  logic [63:0] m_fmt;
  logic [31:0] m_frames;
  longint      m_sum;
  logic [31:0] m_chidx;
  logic [7:0]  m_low;
  logic [31:0] m_fidx;
  logic [31:0] m_bits;
  logic        m_want_data;

  wav_result_t pending_results[$];
  int          fail_count;
  longint      cycle_count;
  int          stim_count;

  // directed stimulus rows
  typedef struct {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        has_result;
    wav_result_t result;
  } stim_row_t;

  stim_row_t directed_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CycleLimit);
    $display("wav_pcm_parse_downmix_core regression: fail");
    $finish;
  end

  function automatic wav_result_t blank_result();
    wav_result_t r;
    r.kind = KindSample;
    r.sample = '0;
    r.sample_rate = '0;
    r.frame_count = '0;
    r.error_code = 1'b0;
    r.is_last = 1'b0;
    return r;
  endfunction

  function automatic wav_result_t error_result(logic code);
    wav_result_t r;
    r = blank_result();
    r.kind = KindError;
    r.error_code = code;
    r.is_last = 1'b1;
    return r;
  endfunction

  function automatic void parser_restart();
    m_phase = PhHead;
    m_pos = '0;
    m_tag = '0;
    m_clen = '0;
    m_skip = '0;
    m_fmt = '0;
    m_frames = '0;
    m_sum = 0;
    m_chidx = '0;
    m_low = '0;
    m_fidx = '0;
    m_bits = '0;
    m_want_data = 1'b0;
  endfunction

  function automatic void enter_chunk_header();
    m_phase = PhHdr;
    m_fidx = '0;
    m_tag = '0;
    m_clen = '0;
  endfunction

  function automatic bit flag_error(logic code, output wav_result_t r);
    r = error_result(code);
    m_phase = PhDone;
    return 1'b1;
  endfunction

  function automatic bit plan_skip(longint unsigned skip, longint unsigned next_hdr,
                                   output wav_result_t r);
    r = blank_result();
    if (next_hdr + 8 > longint'(m_file_len)) return flag_error(ErrFormat, r);
    if (skip == 0) enter_chunk_header();
    else begin
      m_phase = PhSkip;
      m_skip = skip[31:0];
    end
    return 1'b0;
  endfunction

  // returns 1 when the byte yields a result
  function automatic bit parse_byte(logic [7:0] b, logic first, output wav_result_t r);
    logic [31:0] pos;
    logic [31:0] k;
    longint unsigned nxt;
    longint unsigned skip;
    logic [31:0] ch;
    logic [31:0] bps;
    logic [31:0] frames;
    longint v;
    longint mono;
    r = blank_result();
    if (first) parser_restart();
    if (m_phase == PhDone) return 1'b0;
    pos = m_pos;
    m_pos = pos + 1;
    nxt = longint'(pos) + 1;
    case (m_phase)
      PhHead: begin
        if (pos == 0 && m_file_len < 12) return flag_error(ErrFormat, r);
        m_tag |= 32'(b) << (8 * pos[1:0]);
        if (pos == 3) begin
          if (m_tag != TagRiff) return flag_error(ErrFormat, r);
          m_tag = '0;
        end else if (pos == 7) begin
          m_tag = '0;
        end else if (pos == 11) begin
          if (m_tag != TagWave) return flag_error(ErrFormat, r);
          m_want_data = 1'b0;
          return plan_skip(0, 12, r);
        end
        return 1'b0;
      end
      PhHdr: begin
        k = m_fidx & 7;
        m_fidx = k + 1;
        if (k < 4) m_tag |= 32'(b) << (8 * k);
        else m_clen |= 32'(b) << (8 * (k - 4));
        if (k != 7) return 1'b0;
        if (!m_want_data && m_tag == TagFmt) begin
          if (m_clen < 16 || nxt + 16 > longint'(m_file_len)) return flag_error(ErrFormat, r);
          m_phase = PhFmt;
          m_fidx = '0;
          m_fmt = '0;
          m_bits = '0;
          return 1'b0;
        end
        if (m_want_data && m_tag == TagData) begin
          ch = 32'(m_fmt[31:16]);
          bps = (m_bits == 16) ? 2 : 1;
          if (nxt + longint'(m_clen) > longint'(m_file_len)) return flag_error(ErrFormat, r);
          if (ch == 0) return flag_error(ErrFormat, r);
          frames = m_clen / ch / bps;
          if (frames == 0) return flag_error(ErrEmpty, r);
          m_phase = PhData;
          m_frames = frames;
          m_sum = 0;
          m_chidx = '0;
          m_fidx = '0;
          r.kind = KindInfo;
          r.sample_rate = m_fmt[63:32];
          r.frame_count = frames;
          return 1'b1;
        end
        skip = longint'(m_clen) + m_clen[0];
        return plan_skip(skip, nxt + skip, r);
      end
      PhSkip: begin
        if (m_skip > 0) m_skip--;
        if (m_skip == 0) enter_chunk_header();
        return 1'b0;
      end
      PhFmt: begin
        k = m_fidx & 15;
        m_fidx = k + 1;
        if (k < 8) m_fmt |= 64'(b) << (8 * k);
        else if (k == 14) m_bits = 32'(b);
        else if (k == 15) m_bits |= 32'(b) << 8;
        if (k != 15) return 1'b0;
        if (m_fmt[15:0] != 1 || m_fmt[31:16] == 0 || (m_bits != 8 && m_bits != 16))
          return flag_error(ErrFormat, r);
        m_want_data = 1'b1;
        skip = longint'(m_clen) - 16 + m_clen[0];
        return plan_skip(skip, nxt + skip, r);
      end
      PhData: begin
        ch = 32'(m_fmt[31:16]);
        if (m_bits == 16) begin
          if (m_fidx == 0) begin
            m_low = b;
            m_fidx = 1;
            return 1'b0;
          end
          m_fidx = '0;
          v = longint'($signed({b, m_low}));
        end else begin
          v = longint'(b) - 128;
        end
        m_sum += v;
        m_chidx++;
        if (m_chidx < ch || ch == 0) return 1'b0;
        mono = m_sum / longint'(ch);
        if (m_bits != 16) mono *= 256;
        m_sum = 0;
        m_chidx = '0;
        r.sample = mono[15:0];
        if (m_frames > 0) m_frames--;
        if (m_frames == 0) begin
          r.is_last = 1'b1;
          m_phase = PhDone;
        end
        return 1'b1;
      end
      default: begin
        m_phase = PhDone;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic first, bit has_fixed, wav_result_t fixed);
    wav_result_t r;
    bit got;
    int gap;
    gap = $urandom_range(0, 17);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.first_byte <= first;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    got = parse_byte(b, first, r);
    if (has_fixed) begin
      if (!got || r != fixed) begin
        $display("%0t directed byte %h exp kind %0d code %0d got kind %0d code %0d",
                 $time, b, fixed.kind, fixed.error_code, r.kind, r.error_code);
        fail_count++;
      end
    end
    if (got) pending_results.push_back(r);
    stim_count++;
  endtask

  task automatic write_file_length(logic [31:0] len);
    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.file_length <= len;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    m_file_len = len;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic add_row(logic [7:0] b, logic first, bit has_res, wav_result_t r);
    stim_row_t row;
    row.data_byte = b;
    row.first_byte = first;
    row.has_result = has_res;
    row.result = r;
    directed_rows.push_back(row);
  endtask

  task automatic send_u32(logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8], 1'b0, 1'b0, blank_result());
  endtask

  task automatic send_u16(logic [15:0] w);
    send_byte(w[7:0], 1'b0, 1'b0, blank_result());
    send_byte(w[15:8], 1'b0, 1'b0, blank_result());
  endtask

  // build one well-formed (or lightly broken) file with random content
  task automatic send_random_file(int max_frames);
    int unsigned channels;
    int unsigned bits;
    int unsigned fmt_len;
    int unsigned junk_len;
    int unsigned payload_len;
    int unsigned flen;
    int unsigned fmt_code;
    logic [31:0] data_tag;
    int unsigned sel;
    channels = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4);
    if ($urandom_range(0, 20) == 0) channels = 0;
    sel = $urandom_range(0, 19);
    bits = (sel == 0) ? $urandom_range(0, 65535) : (sel < 10 ? 8 : 16);
    fmt_code = ($urandom_range(0, 20) == 0) ? $urandom_range(0, 65535) : 1;
    fmt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 21) : 16;
    junk_len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : 0;
    payload_len = (channels > 4 ? 4 : channels) * (bits == 16 ? 2 : 1) *
                  $urandom_range(0, max_frames) + $urandom_range(0, 2);
    data_tag = ($urandom_range(0, 25) == 0) ? 32'($urandom) : TagData;
    flen = 12 + 8 + fmt_len + fmt_len % 2 + 8 + payload_len;
    if (junk_len != 0) flen += 8 + junk_len + junk_len % 2;
    if ($urandom_range(0, 15) == 0) flen = flen - $urandom_range(0, 10);
    write_file_length(flen);
    send_byte(TagRiff[7:0], 1'b1, 1'b0, blank_result());
    send_byte(TagRiff[15:8], 1'b0, 1'b0, blank_result());
    send_u16(TagRiff[31:16]);
    send_u32(flen - 8);
    send_u32(($urandom_range(0, 30) == 0) ? 32'($urandom) : TagWave);
    if (junk_len != 0) begin
      send_u32(32'($urandom));
      send_u32(32'(junk_len));
      for (int i = 0; i < junk_len + junk_len % 2; i++)
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, blank_result());
    end
    send_u32(TagFmt);
    send_u32(32'(fmt_len));
    send_u16(16'(fmt_code));
    send_u16(16'(channels));
    send_u32($urandom);
    send_u32($urandom);
    send_u16(16'($urandom));
    send_u16(16'(bits));
    for (int i = 16; i < fmt_len + fmt_len % 2; i++)
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, blank_result());
    send_u32(data_tag);
    send_u32(32'(payload_len));
    for (int i = 0; i < payload_len; i++)
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, blank_result());
  endtask

  // result checker
  always @(posedge clk_i) begin
    wav_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat kind %0d", $time, out_ch.kind);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind)
          $display("%0t kind exp %0d got %0d", $time, want.kind, out_ch.kind);
        if (out_ch.sample !== want.sample)
          $display("%0t sample exp %0d got %0d", $time, want.sample, out_ch.sample);
        if (out_ch.sample_rate !== want.sample_rate)
          $display("%0t rate exp %0d got %0d", $time, want.sample_rate, out_ch.sample_rate);
        if (out_ch.frame_count !== want.frame_count)
          $display("%0t frames exp %0d got %0d", $time, want.frame_count,
                   out_ch.frame_count);
        if (out_ch.error_code !== want.error_code)
          $display("%0t error exp %0d got %0d", $time, want.error_code, out_ch.error_code);
        if (out_ch.is_last !== want.is_last)
          $display("%0t last exp %0d got %0d", $time, want.is_last, out_ch.is_last);
        if (out_ch.kind !== want.kind || out_ch.sample !== want.sample ||
            out_ch.sample_rate !== want.sample_rate ||
            out_ch.frame_count !== want.frame_count ||
            out_ch.error_code !== want.error_code || out_ch.is_last !== want.is_last)
          fail_count++;
      end
    end
  end

  // sink stall
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  initial begin
    wav_result_t r;
    fail_count = 0;
    stim_count = 0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.first_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.file_length = '0;
    m_file_len = FileLenRst;
    parser_restart();
    r = blank_result();
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bad RIFF tag at reset length, then ignored byte, short file, bad WAVE, short file
    add_row(8'h00, 1'b1, 1'b0, r);
    add_row(8'hFF, 1'b0, 1'b0, r);
    add_row(8'h80, 1'b0, 1'b0, r);
    add_row(8'h7F, 1'b0, 1'b1, error_result(ErrFormat));
    add_row(8'hAA, 1'b0, 1'b0, r);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data_byte, directed_rows[i].first_byte,
                directed_rows[i].has_result, directed_rows[i].result);
    drain_results();
    write_file_length(32'd11);
    send_byte(8'h52, 1'b1, 1'b1, error_result(ErrFormat));
    drain_results();
    write_file_length(32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++)
      send_byte((i < 4) ? TagRiff[8*i +: 8] : 8'h00, i == 0, i == 11,
                error_result(ErrFormat));
    drain_results();
    write_file_length(32'd1);
    send_byte(8'h52, 1'b1, 1'b1, error_result(ErrFormat));
    drain_results();

    // random files, mostly well-formed
    while (stim_count < 1250) begin
      send_random_file(($urandom_range(0, 9) == 0) ? 40 : 6);
      if ($urandom_range(0, 4) == 0)
        for (int i = 0; i < $urandom_range(1, 6); i++)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0,
                    blank_result());
      drain_results();
    end

    drain_results();
    if (fail_count == 0) $display("wav_pcm_parse_downmix_core regression: pass");
    else $display("wav_pcm_parse_downmix_core regression: fail");
    $finish;
  end
endmodule

FILE: wav_pcm_parse_downmix_core.f
sv/wpd_pkg.sv
sv/wpd_if.sv
sv/wpd_div.sv
sv/wav_pcm_parse_downmix_core.sv
sim/wpd_tb_if.sv
sim/tb_wav_pcm_parse_downmix_core.sv
